@@ sv/stack_with_indexed_remove_top_defines.svh @@
// Assertion macros for the stack with indexed remove RTL
`ifndef STACK_WITH_INDEXED_REMOVE_TOP_DEFINES_SVH
`define STACK_WITH_INDEXED_REMOVE_TOP_DEFINES_SVH

// same-cycle implication
`define SIRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sirm: assertion failed");

// next-cycle implication
`define SIRM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sirm: assertion failed");

`endif

@@ sv/sirm_pkg.sv @@
// Types, constants and codes for the stack with indexed remove
package sirm_pkg;

   localparam int DEPTH    = 64;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_cmd_type;

endpackage

@@ sv/sirm_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port
module sirm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sirm_ctrl.sv @@
// Sequencer: decodes actions, keeps the count and drives the entry memory
`include "stack_with_indexed_remove_top_defines.svh"

module sirm_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sirm_pkg::ACTION_W-1:0]  req_action,
   input  logic [sirm_pkg::ADDR_W-1:0]    req_index,
   input  logic [sirm_pkg::DATA_W-1:0]    req_push_value,
   input  logic                           out_free,
   output logic                           res_fire,
   output sirm_pkg::rsp_type              res,
   output sirm_pkg::mem_cmd_type          mem_cmd,
   input  logic [sirm_pkg::DATA_W-1:0]    mem_rd_data
);

   sirm_pkg::state_type state_ff, state_in;

   logic [sirm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [sirm_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [sirm_pkg::ADDR_W-1:0]   index_ff, index_in;
   logic [sirm_pkg::DATA_W-1:0]   word_ff, word_in;
   logic [sirm_pkg::ADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sirm_pkg::CNT_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sirm_pkg::CNT_W-1:0]    end_ff, end_in;

   logic in_range;
   logic nonempty;
   logic full;
   logic needs_shift;

   assign in_range    = sirm_pkg::CNT_W'(index_ff) < count_ff;
   assign nonempty    = count_ff != '0;
   assign full        = count_ff == sirm_pkg::CNT_W'(sirm_pkg::DEPTH);
   // entries above the removed one must move down
   assign needs_shift = (sirm_pkg::CNT_W'(index_ff) + sirm_pkg::CNT_W'(1)) < count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sirm_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sirm_pkg::S_EXEC;
            end
         end
         sirm_pkg::S_EXEC: begin
            if (out_free) begin
               if (action_ff == sirm_pkg::ACT_REMOVE && in_range && needs_shift) begin
                  state_in = sirm_pkg::S_SHIFT;
               end else begin
                  state_in = sirm_pkg::S_IDLE;
               end
            end
         end
         sirm_pkg::S_SHIFT: begin
            if (rd_ptr_ff >= end_ff) begin
               state_in = sirm_pkg::S_IDLE;
            end
         end
         default: state_in = sirm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      res_fire   = 1'b0;
      res.value  = '0;
      res.status = sirm_pkg::STATUS_OK;
      res.count  = count_ff;
      mem_cmd    = '0;
      count_in   = count_ff;
      action_in  = action_ff;
      index_in   = index_ff;
      word_in    = word_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      end_in     = end_ff;
      case (state_ff)
         sirm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in      = req_action;
               index_in       = req_index;
               word_in        = req_push_value;
               mem_cmd.rd_en  = 1'b1;
               if (req_action == sirm_pkg::ACT_POP || req_action == sirm_pkg::ACT_PEEK) begin
                  mem_cmd.rd_addr = sirm_pkg::ADDR_W'(count_ff - sirm_pkg::CNT_W'(1));
               end else begin
                  mem_cmd.rd_addr = req_index;
               end
            end
         end
         sirm_pkg::S_EXEC: begin
            res_fire = out_free;
            case (action_ff)
               sirm_pkg::ACT_PUSH: begin
                  if (full) begin
                     res.status = sirm_pkg::STATUS_FULL;
                  end else begin
                     res.count       = count_ff + sirm_pkg::CNT_W'(1);
                     mem_cmd.wr_en   = out_free;
                     mem_cmd.wr_addr = sirm_pkg::ADDR_W'(count_ff);
                     mem_cmd.wr_data = word_ff;
                  end
               end
               sirm_pkg::ACT_POP: begin
                  if (nonempty) begin
                     res.value = mem_rd_data;
                     res.count = count_ff - sirm_pkg::CNT_W'(1);
                  end else begin
                     res.status = sirm_pkg::STATUS_MISSING;
                  end
               end
               sirm_pkg::ACT_PEEK: begin
                  if (nonempty) begin
                     res.value = mem_rd_data;
                  end else begin
                     res.status = sirm_pkg::STATUS_MISSING;
                  end
               end
               sirm_pkg::ACT_GET: begin
                  if (in_range) begin
                     res.value = mem_rd_data;
                  end else begin
                     res.status = sirm_pkg::STATUS_MISSING;
                  end
               end
               sirm_pkg::ACT_REMOVE: begin
                  if (in_range) begin
                     res.value = mem_rd_data;
                     res.count = count_ff - sirm_pkg::CNT_W'(1);
                     if (needs_shift) begin
                        // prime the move loop with the word just above the gap
                        mem_cmd.rd_en   = out_free;
                        mem_cmd.rd_addr = index_ff + sirm_pkg::ADDR_W'(1);
                        wr_ptr_in       = index_ff;
                        rd_ptr_in       = sirm_pkg::CNT_W'(index_ff) + sirm_pkg::CNT_W'(2);
                        end_in          = count_ff;
                     end
                  end else begin
                     res.status = sirm_pkg::STATUS_MISSING;
                  end
               end
               sirm_pkg::ACT_CLEAR: begin
                  res.count = '0;
               end
               default: begin
               end
            endcase
            if (out_free) begin
               count_in = res.count;
            end
         end
         sirm_pkg::S_SHIFT: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = wr_ptr_ff;
            mem_cmd.wr_data = mem_rd_data;
            if (rd_ptr_ff < end_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = rd_ptr_ff[sirm_pkg::ADDR_W-1:0];
               rd_ptr_in       = rd_ptr_ff + sirm_pkg::CNT_W'(1);
               wr_ptr_in       = wr_ptr_ff + sirm_pkg::ADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sirm_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      index_ff  <= index_in;
      word_ff   <= word_in;
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      end_ff    <= end_in;
   end

   `SIRM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= sirm_pkg::CNT_W'(sirm_pkg::DEPTH))
   `SIRM_ASSERT_IMP(a_shift_in_bounds, clock, reset, state_ff == sirm_pkg::S_SHIFT,
      (sirm_pkg::CNT_W'(wr_ptr_ff) + sirm_pkg::CNT_W'(1)) < end_ff)
   `SIRM_ASSERT_IMP(a_full_only_at_depth, clock, reset,
      res_fire && res.status == sirm_pkg::STATUS_FULL, full)
   `SIRM_ASSERT_NXT(a_one_word_per_item, clock, reset, res_fire,
      state_ff != sirm_pkg::S_EXEC)
   `SIRM_ASSERT_IMP(a_no_rw_clash, clock, reset, mem_cmd.rd_en && mem_cmd.wr_en,
      mem_cmd.rd_addr != mem_cmd.wr_addr)

endmodule

@@ sv/stack_with_indexed_remove_top.sv @@
// A word is accepted in S_IDLE; its result is registered from S_EXEC once the output register
// is free. No new word is taken until the last one is done; in S_SHIFT a remove moves the entry
// memory one entry down per cycle through its read/write port pair.
// A finished result waits in the output register while the next word is taken in.
// Reset clears the count and control state; the entry memory is not cleared.
module stack_with_indexed_remove_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sirm_pkg::ACTION_W-1:0]  req_action,
   input  logic [sirm_pkg::ADDR_W-1:0]    req_index,
   input  logic [sirm_pkg::DATA_W-1:0]    req_push_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sirm_pkg::DATA_W-1:0]    rsp_result_value,
   output logic [sirm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sirm_pkg::CNT_W-1:0]     rsp_entry_count
);

   sirm_pkg::mem_cmd_type       mem_cmd;
   sirm_pkg::rsp_type           res;
   sirm_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        res_fire;
   logic                        out_free;
   logic [sirm_pkg::DATA_W-1:0] mem_rd_data;

   assign out_free = !rsp_valid_ff || rsp_ready;

   sirm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_push_value (req_push_value),
      .out_free       (out_free),
      .res_fire       (res_fire),
      .res            (res),
      .mem_cmd        (mem_cmd),
      .mem_rd_data    (mem_rd_data)
   );

   sirm_ram #(
      .WIDTH (sirm_pkg::DATA_W),
      .DEPTH (sirm_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (mem_rd_data)
   );

   // output word register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (res_fire) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.value;
   assign rsp_status       = rsp_ff.status;
   assign rsp_entry_count  = rsp_ff.count;

endmodule

@@ sim/stack_with_indexed_remove_checker.sv @@
`timescale 1ns / 1ps
// Stack predictor and result checker for the stack with indexed remove bench
module stack_with_indexed_remove_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [sirm_pkg::ACTION_W-1:0] req_action,
   input  logic [sirm_pkg::ADDR_W-1:0]   req_index,
   input  logic [sirm_pkg::DATA_W-1:0]   req_push_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sirm_pkg::DATA_W-1:0]   rsp_result_value,
   input  logic [sirm_pkg::STATUS_W-1:0] rsp_status,
   input  logic [sirm_pkg::CNT_W-1:0]    rsp_entry_count,
   output int unsigned                   fail_count,
   output int unsigned                   pending_count
);

   localparam int unsigned REPORT_LIMIT = 10;

   logic [sirm_pkg::DATA_W-1:0] stack_words [sirm_pkg::DEPTH];
   logic [sirm_pkg::CNT_W-1:0]  stack_depth;
   sirm_pkg::rsp_type           expected_rsps [$];

   // applies one action to the shadow stack and returns the result it should give
   function automatic sirm_pkg::rsp_type apply_action(
      input logic [sirm_pkg::ACTION_W-1:0] act,
      input logic [sirm_pkg::ADDR_W-1:0]   idx,
      input logic [sirm_pkg::DATA_W-1:0]   word);
      sirm_pkg::rsp_type r;
      r = '{value: '0, status: sirm_pkg::STATUS_OK, count: '0};
      case (act)
         sirm_pkg::ACT_PUSH: begin
            if (stack_depth >= sirm_pkg::DEPTH) begin
               r.status = sirm_pkg::STATUS_FULL;
            end else begin
               stack_words[stack_depth[sirm_pkg::ADDR_W-1:0]] = word;
               stack_depth++;
            end
         end
         sirm_pkg::ACT_POP: begin
            if (stack_depth == 0) begin
               r.status = sirm_pkg::STATUS_MISSING;
            end else begin
               stack_depth--;
               r.value = stack_words[stack_depth[sirm_pkg::ADDR_W-1:0]];
            end
         end
         sirm_pkg::ACT_PEEK: begin
            if (stack_depth == 0) r.status = sirm_pkg::STATUS_MISSING;
            else r.value = stack_words[sirm_pkg::ADDR_W'(stack_depth - 1'b1)];
         end
         sirm_pkg::ACT_GET: begin
            if ({1'b0, idx} >= stack_depth) r.status = sirm_pkg::STATUS_MISSING;
            else r.value = stack_words[idx];
         end
         sirm_pkg::ACT_REMOVE: begin
            if ({1'b0, idx} >= stack_depth) begin
               r.status = sirm_pkg::STATUS_MISSING;
            end else begin
               r.value = stack_words[idx];
               // close the gap: later entries move down one place
               for (int i = idx; i + 1 < stack_depth; i++)
                  stack_words[sirm_pkg::ADDR_W'(i)] = stack_words[sirm_pkg::ADDR_W'(i + 1)];
               stack_depth--;
            end
         end
         sirm_pkg::ACT_CLEAR: stack_depth = '0;
         default: ;
      endcase
      r.count = stack_depth;
      return r;
   endfunction

   task automatic flag_mismatch(input bit have_want, input sirm_pkg::rsp_type want,
                                input sirm_pkg::rsp_type seen);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         if (!have_want)
            $display("%0t: unexpected result word value=%h status=%0d count=%0d",
                     $realtime, seen.value, seen.status, seen.count);
         else
            $display({"%0t: mismatch value exp=%h act=%h status exp=%0d act=%0d",
                      " count exp=%0d act=%0d"},
                     $realtime, want.value, seen.value, want.status, seen.status,
                     want.count, seen.count);
      end
   endtask

   always @(posedge clock) begin
      sirm_pkg::rsp_type seen;
      sirm_pkg::rsp_type want;
      if (reset) begin
         expected_rsps.delete();
         stack_depth = '0;
         fail_count  = 0;
      end else begin
         // result side first: a result can never belong to a word taken at the same edge
         if (rsp_valid && rsp_ready) begin
            seen = '{value: rsp_result_value, status: rsp_status, count: rsp_entry_count};
            if (expected_rsps.size() == 0) begin
               flag_mismatch(1'b0, seen, seen);
            end else begin
               want = expected_rsps.pop_front();
               if (seen !== want) flag_mismatch(1'b1, want, seen);
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_action(req_action, req_index, req_push_value));
      end
      pending_count = expected_rsps.size();
   end

endmodule

@@ sim/stack_with_indexed_remove_top_tb.sv @@
`timescale 1ns / 1ps
// Stimulus, clocking and verdict for the stack with indexed remove
module stack_with_indexed_remove_top_tb;

   localparam logic [sirm_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [sirm_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sirm_pkg::ACTION_W-1:0] req_action = sirm_pkg::ACT_PEEK;
   logic [sirm_pkg::ADDR_W-1:0]   req_index = '0;
   logic [sirm_pkg::DATA_W-1:0]   req_push_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [sirm_pkg::DATA_W-1:0]   rsp_result_value;
   logic [sirm_pkg::STATUS_W-1:0] rsp_status;
   logic [sirm_pkg::CNT_W-1:0]    rsp_entry_count;
   int unsigned                   fail_count;
   int unsigned                   pending_count;

   int idle_pct = 0;
   int stall_pct = 0;
   bit long_hold = 1'b0;

   stack_with_indexed_remove_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   stack_with_indexed_remove_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // ready is sampled at the falling edge, where it has settled for the coming rising edge
   task automatic send_word(input logic [sirm_pkg::ACTION_W-1:0] act,
                            input logic [sirm_pkg::ADDR_W-1:0] idx,
                            input logic [sirm_pkg::DATA_W-1:0] word);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_index      <= idx;
      req_push_value <= word;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic send_random(input int push_w, input bit allow_clear);
      logic [sirm_pkg::ACTION_W-1:0] act;
      logic [sirm_pkg::ADDR_W-1:0]   idx;
      int                            pick;
      pick = $urandom_range(0, 99);
      if (pick < push_w) begin
         act = sirm_pkg::ACT_PUSH;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      act = sirm_pkg::ACT_POP;
         else if (pick < 45) act = sirm_pkg::ACT_PEEK;
         else if (pick < 65) act = sirm_pkg::ACT_GET;
         else if (pick < 90) act = sirm_pkg::ACT_REMOVE;
         else if (pick < 95) act = allow_clear ? sirm_pkg::ACT_CLEAR : sirm_pkg::ACT_POP;
         else                act = pick[0] ? ACT_SPARE_B : ACT_SPARE_A;
      end
      // low indices are more likely to land inside a shallow stack
      idx = $urandom_range(0, 1) ? sirm_pkg::ADDR_W'($urandom_range(0, 63))
                                 : sirm_pkg::ADDR_W'($urandom_range(0, 15));
      send_word(act, idx, $urandom());
   endtask

   // result side: random stall bursts, one long hold-off on request, none in the tail
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            long_hold = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      int push_w;
      bit allow_clear;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, value extremes, index extremes, removes, spare codes, clear
      send_word(sirm_pkg::ACT_POP,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_PEEK,   6'd63, 32'hFFFF_FFFF);
      send_word(sirm_pkg::ACT_GET,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_REMOVE, 6'd63, 32'h0);
      send_word(sirm_pkg::ACT_PUSH,   6'd0,  32'h0000_0000);
      send_word(sirm_pkg::ACT_PUSH,   6'd63, 32'hFFFF_FFFF);
      send_word(sirm_pkg::ACT_PUSH,   6'd21, 32'hA5A5_5A5A);
      send_word(sirm_pkg::ACT_PEEK,   6'd0,  32'h0);
      send_word(sirm_pkg::ACT_GET,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_GET,    6'd2,  32'h0);
      send_word(sirm_pkg::ACT_GET,    6'd3,  32'h0);
      send_word(sirm_pkg::ACT_GET,    6'd63, 32'h0);
      send_word(sirm_pkg::ACT_REMOVE, 6'd0,  32'h0);
      send_word(sirm_pkg::ACT_GET,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_REMOVE, 6'd1,  32'h0);
      send_word(ACT_SPARE_A,          6'd42, 32'h5555_AAAA);
      send_word(ACT_SPARE_B,          6'd63, 32'hFFFF_FFFF);
      send_word(sirm_pkg::ACT_PUSH,   6'd0,  32'h1234_5678);
      send_word(sirm_pkg::ACT_POP,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_POP,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_POP,    6'd0,  32'h0);
      send_word(sirm_pkg::ACT_PUSH,   6'd0,  32'hDEAD_BEEF);
      send_word(sirm_pkg::ACT_PUSH,   6'd0,  32'h8000_0001);
      send_word(sirm_pkg::ACT_CLEAR,  6'd63, 32'hFFFF_FFFF);
      send_word(sirm_pkg::ACT_PEEK,   6'd0,  32'h0);

      // random: fill to overflow, mixed under a long hold-off, drain, refill, quiet tail
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin push_w = 90; allow_clear = 1'b0; idle_pct = 30; stall_pct = 30; end
            1: begin
               push_w = 50; allow_clear = 1'b1; idle_pct = 0; stall_pct = 20;
               long_hold = 1'b1;
            end
            2: begin push_w = 15; allow_clear = 1'b0; idle_pct = 25; stall_pct = 0; end
            3: begin push_w = 90; allow_clear = 1'b0; idle_pct = 35; stall_pct = 35; end
            default: begin push_w = 50; allow_clear = 1'b1; idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
            send_random(push_w, allow_clear);
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/sirm_pkg.sv
sv/sirm_ram.sv
sv/sirm_ctrl.sv
sv/stack_with_indexed_remove_top.sv
sim/stack_with_indexed_remove_checker.sv
sim/stack_with_indexed_remove_top_tb.sv
